>>> rtl/core/frs_pkg.sv
// Package for the frame resequencing sorter: frame type, sizes and state codes.
// Depends on nothing; used by frs_cell and frame_resequencing_sorter.
`default_nettype none

package frs_pkg;

  localparam int MAX_FRAMES        = 16;
  localparam int MAX_PAYLOAD_BYTES = 10;

  localparam int SEQ_W = 8;
  localparam int LEN_W = 4;
  localparam int PLO_W = 64;
  localparam int PHI_W = 16;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [PLO_W-1:0] plo;
    logic [PHI_W-1:0] phi;
  } frame_t;

  // per-cycle command broadcast down the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } chain_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } sort_state_t;

  // clamp the length and zero the bytes at or beyond it
  function automatic frame_t make_frame(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len,
                                        logic [PLO_W-1:0] lo, logic [PHI_W-1:0] hi);
    frame_t f;
    logic [LEN_W-1:0] n;
    n = (len > LEN_W'(MAX_PAYLOAD_BYTES)) ? LEN_W'(MAX_PAYLOAD_BYTES) : len;
    f.seq = seq;
    f.len = n;
    f.plo = lo;
    f.phi = hi;
    for (int b = 0; b < PLO_W / 8; b++) begin
      if (LEN_W'(b) >= n) f.plo[b*8 +: 8] = 8'h00;
    end
    for (int b = 0; b < PHI_W / 8; b++) begin
      if (LEN_W'(b + PLO_W / 8) >= n) f.phi[b*8 +: 8] = 8'h00;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/frs_cell.sv
// One cell of the insertion chain: holds one frame and its valid bit.
// Depends on frs_pkg.
`default_nettype none

module frs_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire frs_pkg::chain_ctrl_t ctrl,
  input  wire frs_pkg::frame_t      ins_frame,
  input  wire                       prev_gt,
  input  wire                       prev_valid,
  input  wire frs_pkg::frame_t      prev_frame,
  input  wire                       next_valid,
  input  wire frs_pkg::frame_t      next_frame,
  output logic                      gt,
  output logic                      valid,
  output frs_pkg::frame_t           frame
);
  import frs_pkg::*;

  logic   valid_r, valid_nxt;
  frame_t frame_r, frame_nxt;

  // empty cells count as +inf; strict compare keeps equal keys in arrival order
  assign gt = !valid_r || (frame_r.seq > ins_frame.seq);

  always_comb begin
    valid_nxt = valid_r;
    frame_nxt = frame_r;
    if (ctrl.shift) begin
      valid_nxt = next_valid;
      frame_nxt = next_frame;
    end else if (ctrl.insert && gt) begin
      if (prev_gt) begin
        valid_nxt = prev_valid;
        frame_nxt = prev_frame;
      end else begin
        valid_nxt = 1'b1;
        frame_nxt = ins_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    frame_r <= frame_nxt;
  end

  assign valid = valid_r;
  assign frame = frame_r;

endmodule

`default_nettype wire

>>> rtl/core/frame_resequencing_sorter.sv
// Frame resequencing sorter top level: chain of frs_cell plus fill/drain control.
// Depends on frs_pkg and frs_cell.
`default_nettype none

// Usage
//  Input channel (in_*): one frame per word. Each accepted frame is placed in a
//  sorted chain of MAX_FRAMES cells in the cycle it is accepted, after any frame
//  with an equal sequence number. A frame arriving with the chain full is
//  dropped and sets the overflow flag.
//  A word with in_set_end high closes the set: the block stalls its input and
//  drains the chain on the output channel (out_*), lowest sequence number
//  first, with out_last on the final word and out_overflowed on every word.
//  Throughput: one frame per cycle while filling; one word per cycle while
//  draining unless the receiver stalls. The first sorted word is valid the
//  cycle after the closing frame is accepted; the input stays stalled until
//  the last word of the set is taken. The rates are set by the chain, which
//  either inserts or unloads, never both at once.
//  out_stall holds the head cell in place; nothing is lost or repeated.
//  Reset (rst_n low, synchronous) empties the chain, clears the overflow flag
//  and returns to filling. No clearing pass is needed.
module frame_resequencing_sorter (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [frs_pkg::SEQ_W-1:0]   in_seq_num,
  input  wire  [frs_pkg::LEN_W-1:0]   in_frame_len,
  input  wire  [frs_pkg::PLO_W-1:0]   in_payload_low,
  input  wire  [frs_pkg::PHI_W-1:0]   in_payload_high,
  input  wire                         in_set_end,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [frs_pkg::SEQ_W-1:0]   out_seq,
  output logic [frs_pkg::LEN_W-1:0]   out_len,
  output logic [frs_pkg::PLO_W-1:0]   out_payload_low,
  output logic [frs_pkg::PHI_W-1:0]   out_payload_high,
  output logic                        out_last,
  output logic                        out_overflowed
);
  import frs_pkg::*;

  sort_state_t state_r, state_nxt;
  logic        drop_r, drop_nxt;

  chain_ctrl_t            ctrl;
  frame_t                 ins_frame;
  frame_t                 cell_frame [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]  cell_vld;
  logic [MAX_FRAMES-1:0]  cell_gt;

  logic in_acc;
  logic out_acc;
  logic full;
  logic drain_done;

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  assign ins_frame = make_frame(in_seq_num, in_frame_len, in_payload_low, in_payload_high);
  assign full      = cell_vld[MAX_FRAMES-1];
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign drain_done = out_acc && out_last;

  // ---------------------------------------------------------------------------
  // cell chain: insert broadcasts the new word, shift unloads toward cell 0
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic   prev_gt;
    logic   prev_valid;
    frame_t prev_frame;
    logic   next_valid;
    frame_t next_frame;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_frame = ins_frame;
    end else begin : g_body
      assign prev_gt    = cell_gt[i-1];
      assign prev_valid = cell_vld[i-1];
      assign prev_frame = cell_frame[i-1];
    end

    if (i == MAX_FRAMES - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_frame = cell_frame[i];
    end else begin : g_mid
      assign next_valid = cell_vld[i+1];
      assign next_frame = cell_frame[i+1];
    end

    frs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .ins_frame  (ins_frame),
      .prev_gt    (prev_gt),
      .prev_valid (prev_valid),
      .prev_frame (prev_frame),
      .next_valid (next_valid),
      .next_frame (next_frame),
      .gt         (cell_gt[i]),
      .valid      (cell_vld[i]),
      .frame      (cell_frame[i])
    );
  end

  // ---------------------------------------------------------------------------
  // control: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (in_acc && in_set_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_done) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // control: outputs
  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    case (state_r)
      ST_FILL: begin
        in_stall    = 1'b0;
        ctrl.insert = in_acc && !full;
      end
      ST_DRAIN: begin
        out_valid  = cell_vld[0];
        ctrl.shift = out_acc;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // overflow flag: set on a drop, cleared once the set is fully unloaded
  always_comb begin
    drop_nxt = drop_r;
    if (drain_done)         drop_nxt = 1'b0;
    else if (in_acc && full) drop_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // head cell drives the result word directly (already registered)
  assign out_seq          = cell_frame[0].seq;
  assign out_len          = cell_frame[0].len;
  assign out_payload_low  = cell_frame[0].plo;
  assign out_payload_high = cell_frame[0].phi;
  assign out_last         = !cell_vld[1];
  assign out_overflowed   = drop_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  logic order_bad;
  always_comb begin
    order_bad = 1'b0;
    for (int i = 0; i < MAX_FRAMES - 1; i++) begin
      if (cell_vld[i+1] && (cell_frame[i].seq > cell_frame[i+1].seq)) order_bad = 1'b1;
    end
  end

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n) !order_bad)
    else $error("chain out of order");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_vld & (cell_vld + 1'b1)) == '0)
    else $error("valid cells not contiguous from head");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> cell_vld[0])
    else $error("drain with empty chain");

  a_empty_after: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |=> (cell_vld == '0) && !drop_r)
    else $error("chain or flag not cleared after last word");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> drop_r)
    else $error("drop not flagged");

endmodule

`default_nettype wire

>>> tb/frs_sort_checker.sv
`timescale 1ns / 100ps
// Checker for frame_resequencing_sorter: watches both word channels, rebuilds each
// sorted set from the accepted frames and compares every output word field by field.
// Depends on frs_pkg for the frame type and the buffer sizes.
module frs_sort_checker (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire  [frs_pkg::SEQ_W-1:0]  in_seq_num,
  input  wire  [frs_pkg::LEN_W-1:0]  in_frame_len,
  input  wire  [frs_pkg::PLO_W-1:0]  in_payload_low,
  input  wire  [frs_pkg::PHI_W-1:0]  in_payload_high,
  input  wire                        in_set_end,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire  [frs_pkg::SEQ_W-1:0]  out_seq,
  input  wire  [frs_pkg::LEN_W-1:0]  out_len,
  input  wire  [frs_pkg::PLO_W-1:0]  out_payload_low,
  input  wire  [frs_pkg::PHI_W-1:0]  out_payload_high,
  input  wire                        out_last,
  input  wire                        out_overflowed,
  output int                         error_count,
  output int                         words_owed
);
  import frs_pkg::*;

  typedef struct packed {
    frame_t frm;
    logic   last;
    logic   ovf;
  } sorted_word_t;

  frame_t       held_frames[$];   // frames of the open set, arrival order
  logic         set_dropped;      // a frame of the open set was lost to a full buffer
  sorted_word_t words_due[$];     // sorted words not yet seen on the output

  initial begin
    error_count = 0;
    words_owed  = 0;
    set_dropped = 1'b0;
  end

  // length saturates at the payload size; bytes at or past it read as zero
  function automatic frame_t trim_frame(input logic [SEQ_W-1:0] seq,
                                        input logic [LEN_W-1:0] len,
                                        input logic [PLO_W-1:0] lo,
                                        input logic [PHI_W-1:0] hi);
    frame_t                   f;
    logic [PHI_W+PLO_W-1:0]   bytes;
    int                       keep;
    keep  = (len > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : int'(len);
    bytes = {hi, lo};
    for (int b = keep; b < (PHI_W + PLO_W) / 8; b++) bytes[b*8 +: 8] = 8'h00;
    f.seq          = seq;
    f.len          = LEN_W'(keep);
    {f.phi, f.plo} = bytes;
    return f;
  endfunction

  // stable sort of the open set; ties stay in arrival order
  task automatic close_set();
    frame_t       ordered[$];
    int           pos;
    sorted_word_t w;
    foreach (held_frames[i]) begin
      pos = ordered.size();
      while (pos > 0 && ordered[pos-1].seq > held_frames[i].seq) pos--;
      ordered.insert(pos, held_frames[i]);
    end
    foreach (ordered[i]) begin
      w.frm  = ordered[i];
      w.last = (i == ordered.size() - 1);
      w.ovf  = set_dropped;
      words_due.push_back(w);
    end
    held_frames.delete();
    set_dropped = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    sorted_word_t w;
    if (!rst_n) begin
      held_frames.delete();
      set_dropped = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          $error("out word with none pending: seq %0h", out_seq);
          error_count++;
        end else begin
          w = words_due.pop_front();
          check_field("out_seq", w.frm.seq, out_seq);
          check_field("out_len", w.frm.len, out_len);
          check_field("out_payload_low", w.frm.plo, out_payload_low);
          check_field("out_payload_high", w.frm.phi, out_payload_high);
          check_field("out_last", w.last, out_last);
          check_field("out_overflowed", w.ovf, out_overflowed);
        end
      end
      if (in_valid && !in_stall) begin
        if (held_frames.size() < MAX_FRAMES)
          held_frames.push_back(trim_frame(in_seq_num, in_frame_len,
                                           in_payload_low, in_payload_high));
        else
          set_dropped = 1'b1;
        if (in_set_end) close_set();
      end
    end
    words_owed = words_due.size();
  end

endmodule

>>> tb/frame_resequencing_sorter_tb.sv
`timescale 1ns / 100ps
// Testbench top for frame_resequencing_sorter: clock, reset, frame stimulus,
// receiver stalls and the verdict. Depends on frs_pkg, the block and frs_sort_checker.
module frame_resequencing_sorter_tb;
  import frs_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving before giving up
  localparam int TOTAL_FRAMES = 280;   // stimulus stops once this many are in
  localparam int CALM_FROM    = 230;   // no idling on either side past this point
  localparam int LONG_HOLD    = 150;   // one long receiver hold-off, in cycles

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [SEQ_W-1:0] in_seq_num = '0;
  logic [LEN_W-1:0] in_frame_len = '0;
  logic [PLO_W-1:0] in_payload_low = '0;
  logic [PHI_W-1:0] in_payload_high = '0;
  logic             in_set_end = 1'b0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [SEQ_W-1:0] out_seq;
  logic [LEN_W-1:0] out_len;
  logic [PLO_W-1:0] out_payload_low;
  logic [PHI_W-1:0] out_payload_high;
  logic             out_last;
  logic             out_overflowed;

  int error_count;
  int words_owed;
  int frames_sent = 0;   // frames accepted by the block
  int words_taken = 0;   // sorted words accepted from the block
  bit calm = 1'b0;       // set near the end: both sides stop idling

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_resequencing_sorter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_seq_num       (in_seq_num),
    .in_frame_len     (in_frame_len),
    .in_payload_low   (in_payload_low),
    .in_payload_high  (in_payload_high),
    .in_set_end       (in_set_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seq          (out_seq),
    .out_len          (out_len),
    .out_payload_low  (out_payload_low),
    .out_payload_high (out_payload_high),
    .out_last         (out_last),
    .out_overflowed   (out_overflowed)
  );

  frs_sort_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_seq_num       (in_seq_num),
    .in_frame_len     (in_frame_len),
    .in_payload_low   (in_payload_low),
    .in_payload_high  (in_payload_high),
    .in_set_end       (in_set_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seq          (out_seq),
    .out_len          (out_len),
    .out_payload_low  (out_payload_low),
    .out_payload_high (out_payload_high),
    .out_last         (out_last),
    .out_overflowed   (out_overflowed),
    .error_count      (error_count),
    .words_owed       (words_owed)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) words_taken <= words_taken + 1;
  end

  // ---------------------------------------------------------------------------
  // Sender side. Fields change only on the falling edge and only after the
  // previous word was taken, so a stalled word holds still.
  // ---------------------------------------------------------------------------
  task automatic send_frame(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                            input logic [PLO_W-1:0] lo, input logic [PHI_W-1:0] hi,
                            input logic closes);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_seq_num      <= seq;
    in_frame_len    <= len;
    in_payload_low  <= lo;
    in_payload_high <= hi;
    in_set_end      <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
    if (frames_sent >= CALM_FROM) calm = 1'b1;
  endtask

  // hold valid low to leave a gap between frames
  task automatic sender_gap(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // hold off until every sorted word owed so far has come out
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
  endtask

  // one set of random frames, the last one closing it; a small key range
  // forces many equal sequence numbers so the tie order gets exercised
  task automatic send_set(input int count, input int seq_top, input bit gappy);
    for (int i = 0; i < count; i++) begin
      if (gappy && !calm && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 16));
      send_frame(SEQ_W'($urandom_range(0, seq_top)), LEN_W'($urandom_range(0, 15)),
                 {$urandom, $urandom}, PHI_W'($urandom), i == count - 1);
    end
  endtask

  initial begin : stimulus
    int  set_size;
    int  pick;
    bit  paused_once;
    paused_once = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // lone frame that closes its own set; length above the payload size saturates
    send_frame(8'hFF, 4'hF, '1, '1, 1'b1);
    // exactly a full buffer: every length 0..15 on all-ones payload, so the
    // byte zeroing shows, with keys 0..2, 254 and 255 and repeats in mixed order
    for (int i = 0; i < MAX_FRAMES; i++)
      send_frame((i % 2) ? SEQ_W'(255 - ((i / 2) % 2)) : SEQ_W'(i % 3),
                 LEN_W'(i), '1, '1, i == MAX_FRAMES - 1);
    // interleaved equal keys: tie order must follow arrival
    for (int i = 0; i < 6; i++)
      send_frame(SEQ_W'(9 - (i % 2)), LEN_W'(15 - 3 * i), {$urandom, $urandom},
                 PHI_W'($urandom), i == 5);
    drain_wait();

    // random sets: mostly fitting, some exactly full, some overrunning the
    // buffer so the closing frame itself is dropped
    while (frames_sent < TOTAL_FRAMES) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)      set_size = $urandom_range(1, MAX_FRAMES);
      else if (pick < 15) set_size = MAX_FRAMES;
      else if (pick < 17) set_size = MAX_FRAMES + 1;
      else                set_size = $urandom_range(MAX_FRAMES + 2, MAX_FRAMES + 6);
      send_set(set_size, $urandom_range(0, 1) ? 255 : 3, $urandom_range(0, 2) != 0);
      if (!paused_once && frames_sent >= 150) begin
        paused_once = 1'b1;
        drain_wait();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0 && words_owed == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side. Stall bursts come in stretches that are either gappy or
  // clean, plus one long hold-off once output is flowing so the chain backs
  // up and the input sees stall during a drain.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int mode_left;
    bit gappy;
    bit long_done;
    hold_left = 0;
    mode_left = 0;
    gappy     = 1'b0;
    long_done = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        gappy     = ($urandom_range(0, 2) != 0);
        mode_left = 64;
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!long_done && words_taken >= 40) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end else if (gappy && !calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 16);
      end
      out_stall <= (hold_left > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if no word moves on either channel for too long.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule
